@@ hw/rtl/ujse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ujse_pkg
// Shared types and codes of the UTF-8 to JSON string escaper: the command
// word that travels from the classifier to the character sequencer.
// ----------------------------------------------------------------------------
package ujse_pkg;

    // Body of a command: what the input byte itself expands to.
    localparam logic [2:0] BODY_NONE = 3'd0;  // no body characters
    localparam logic [2:0] BODY_CHAR = 3'd1;  // one plain character
    localparam logic [2:0] BODY_BSLC = 3'd2;  // backslash, then the character
    localparam logic [2:0] BODY_ESC1 = 3'd3;  // one \uXXXX escape
    localparam logic [2:0] BODY_ESC2 = 3'd4;  // surrogate pair, two escapes

    // Tail of a command: what follows the body.
    localparam logic [1:0] TAIL_NONE  = 2'd0;
    localparam logic [1:0] TAIL_CLOSE = 2'd1; // closing quote
    localparam logic [1:0] TAIL_ERR   = 2'd2; // error word, string aborted

    // Characters used by both sides.
    localparam logic [6:0] CH_QUOTE = 7'h22;
    localparam logic [6:0] CH_BSLC  = 7'h5c;
    localparam logic [6:0] CH_U     = 7'h75;

    // One command: everything that one input word produces.
    typedef struct packed {
        logic        open;   // opening quote first
        logic [2:0]  body;   // BODY_* code
        logic [6:0]  ch;     // character for BODY_CHAR and BODY_BSLC
        logic [15:0] val1;   // first escape value
        logic [15:0] val2;   // second escape value (low surrogate)
        logic [1:0]  tail;   // TAIL_* code
    } t_cmd;

endpackage

@@ hw/rtl/ujse_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ujse_front
// Accepts input words, tracks the UTF-8 decoding state and turns each word
// into one command for the character sequencer.
// ----------------------------------------------------------------------------
module ujse_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_has_byte,
    input  logic          i_is_first,
    input  logic          i_is_last,
    input  logic          i_full,
    output logic          o_push,
    output ujse_pkg::t_cmd o_cmd
);

    logic [1:0]  r_pend, n_pend;
    logic [20:0] r_acc, n_acc;
    logic [1:0]  r_cls, n_cls;
    logic        r_err, n_err;

    logic        w_accept;
    logic [20:0] w_cp;
    logic [20:0] w_min;
    logic [19:0] w_ofs;
    logic [1:0]  w_pend_dec;
    logic        w_bad;
    ujse_pkg::t_cmd w_cmd;

    function automatic logic [14:0] n_acc_base(input logic [20:0] acc, input logic first);
        n_acc_base = first ? 15'd0 : acc[14:0];
    endfunction

    assign w_accept = i_valid && !i_full;

    // Code point after appending this continuation byte, and its overlong limit.
    assign w_cp = {n_acc_base(r_acc, i_is_first), i_in_byte[5:0]};
    assign w_ofs = 20'(w_cp - 21'h010000);
    assign w_pend_dec = 2'((i_is_first ? 2'd0 : r_pend) - 2'd1);

    always_comb begin
        unique case (i_is_first ? 2'd0 : r_cls)
            2'd1:    w_min = 21'h000080;
            2'd2:    w_min = 21'h000800;
            default: w_min = 21'h010000;
        endcase
    end

    // Classify the word: state as it stands after any is_first reset.
    always_comb begin
        n_pend = i_is_first ? 2'd0 : r_pend;
        n_acc  = i_is_first ? 21'd0 : r_acc;
        n_cls  = i_is_first ? 2'd0 : r_cls;
        n_err  = i_is_first ? 1'b0 : r_err;
        w_bad  = 1'b0;
        w_cmd.open = i_is_first;
        w_cmd.body = ujse_pkg::BODY_NONE;
        w_cmd.ch   = i_in_byte[6:0];
        w_cmd.val1 = {8'h00, i_in_byte};
        w_cmd.val2 = 16'h0000;
        w_cmd.tail = ujse_pkg::TAIL_NONE;

        if (!n_err && i_has_byte) begin
            if (n_pend != 2'd0) begin
                if (i_in_byte[7:6] != 2'b10) begin
                    w_bad = 1'b1;
                end else if (w_pend_dec != 2'd0) begin
                    n_pend = w_pend_dec;
                    n_acc  = w_cp;
                end else begin
                    n_pend = 2'd0;
                    n_acc  = 21'd0;
                    n_cls  = 2'd0;
                    if (w_cp < w_min || w_cp > 21'h10ffff ||
                        (w_cp >= 21'h00d800 && w_cp <= 21'h00dfff)) begin
                        w_bad = 1'b1;
                    end else if (w_cp < 21'h010000) begin
                        w_cmd.body = ujse_pkg::BODY_ESC1;
                        w_cmd.val1 = w_cp[15:0];
                    end else begin
                        w_cmd.body = ujse_pkg::BODY_ESC2;
                        w_cmd.val1 = {6'b110110, w_ofs[19:10]};
                        w_cmd.val2 = {6'b110111, w_ofs[9:0]};
                    end
                end
            end else begin
                priority if (i_in_byte == 8'h22 || i_in_byte == 8'h5c) begin
                    w_cmd.body = ujse_pkg::BODY_BSLC;
                end else if (i_in_byte < 8'h20) begin
                    w_cmd.body = ujse_pkg::BODY_ESC1;
                end else if (i_in_byte < 8'h80) begin
                    w_cmd.body = ujse_pkg::BODY_CHAR;
                end else if (i_in_byte >= 8'hc2 && i_in_byte <= 8'hdf) begin
                    n_pend = 2'd1;
                    n_cls  = 2'd1;
                    n_acc  = {16'd0, i_in_byte[4:0]};
                end else if (i_in_byte >= 8'he0 && i_in_byte <= 8'hef) begin
                    n_pend = 2'd2;
                    n_cls  = 2'd2;
                    n_acc  = {17'd0, i_in_byte[3:0]};
                end else if (i_in_byte >= 8'hf0 && i_in_byte <= 8'hf4) begin
                    n_pend = 2'd3;
                    n_cls  = 2'd3;
                    n_acc  = {18'd0, i_in_byte[2:0]};
                end else begin
                    w_bad = 1'b1;
                end
            end
        end

        // End of string: closing quote, or an error for a truncated sequence.
        if (!n_err && !w_bad && i_is_last) begin
            if (n_pend != 2'd0) begin
                w_bad = 1'b1;
            end else begin
                w_cmd.tail = ujse_pkg::TAIL_CLOSE;
            end
        end

        // An error clears the decoder and blocks the rest of the string.
        if (w_bad) begin
            n_err  = 1'b1;
            n_pend = 2'd0;
            n_acc  = 21'd0;
            n_cls  = 2'd0;
            w_cmd.tail = ujse_pkg::TAIL_ERR;
        end
    end

    // Decoder state advances only on accepted words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_acc  <= 21'd0;
            r_cls  <= 2'd0;
            r_err  <= 1'b0;
        end else if (w_accept) begin
            r_pend <= n_pend;
            r_acc  <= n_acc;
            r_cls  <= n_cls;
            r_err  <= n_err;
        end
    end

    // A word with no result characters is not queued.
    assign o_push = w_accept &&
                    (w_cmd.open || w_cmd.body != ujse_pkg::BODY_NONE ||
                     w_cmd.tail != ujse_pkg::TAIL_NONE);
    assign o_cmd  = w_cmd;

    // An error word always latches the abort state.
    a_err_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.tail == ujse_pkg::TAIL_ERR) |=> r_err)
        else $error("error word sent without latching the abort state");

    // While aborted, only a new string produces output.
    a_abort_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && w_accept && !i_is_first) |-> !o_push)
        else $error("output produced inside an aborted string");

    // Pending continuations always come with a sequence class.
    a_pend_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 2'd0) |-> (r_cls != 2'd0 && r_err == 1'b0))
        else $error("pending continuations without a sequence class");

endmodule

@@ hw/rtl/ujse_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ujse_queue
// Small register queue of commands between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module ujse_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ujse_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output ujse_pkg::t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ujse_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wptr, n_wptr;
    logic [AW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_count, n_count;
    logic           w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != CW'(0));
    assign o_cmd   = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointer and fill count bookkeeping.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? AW'(0) : AW'(r_wptr + AW'(1));
        end
        if (w_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? AW'(0) : AW'(r_rptr + AW'(1));
        end
        if (w_push && !w_pop) begin
            n_count = CW'(r_count + CW'(1));
        end else if (!w_push && w_pop) begin
            n_count = CW'(r_count - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

@@ hw/rtl/ujse_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ujse_back
// Character sequencer: expands one queued command into its output words,
// one character per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
module ujse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  ujse_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [6:0]     o_out_char,
    output logic           o_run_last,
    output logic           o_string_end,
    output logic           o_bad_utf8
);

    localparam logic [1:0] PH_OPEN = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_TAIL = 2'd2;

    logic           r_busy, n_busy;
    logic [1:0]     r_phase, n_phase;
    logic [3:0]     r_j, n_j;
    ujse_pkg::t_cmd r_cmd;

    logic           w_fire;
    logic           w_body_last;
    logic           w_hi;
    logic [3:0]     w_q;
    logic [15:0]     w_val;
    logic [6:0]     w_body_ch;

    function automatic logic [6:0] f_hex(input logic [3:0] n);
        f_hex = (n < 4'd10) ? 7'(7'h30 + {3'b000, n}) : 7'(7'h57 + {3'b000, n});
    endfunction

    // Position inside an escape: which of the two groups, and the slot in it.
    assign w_hi  = (r_j >= 4'd6);
    assign w_q   = w_hi ? 4'(r_j - 4'd6) : r_j;
    assign w_val = w_hi ? r_cmd.val2 : r_cmd.val1;

    always_comb begin
        unique case (w_q)
            4'd0:    w_body_ch = ujse_pkg::CH_BSLC;
            4'd1:    w_body_ch = ujse_pkg::CH_U;
            4'd2:    w_body_ch = f_hex(w_val[15:12]);
            4'd3:    w_body_ch = f_hex(w_val[11:8]);
            4'd4:    w_body_ch = f_hex(w_val[7:4]);
            default: w_body_ch = f_hex(w_val[3:0]);
        endcase
    end

    always_comb begin
        unique case (r_cmd.body)
            ujse_pkg::BODY_CHAR: w_body_last = 1'b1;
            ujse_pkg::BODY_BSLC: w_body_last = (r_j == 4'd1);
            ujse_pkg::BODY_ESC1: w_body_last = (r_j == 4'd5);
            default:             w_body_last = (r_j == 4'd11);
        endcase
    end

    // Output word from the current command and position.
    always_comb begin
        o_out_char   = ujse_pkg::CH_QUOTE;
        o_string_end = 1'b0;
        o_bad_utf8   = 1'b0;
        o_run_last   = 1'b0;
        unique case (r_phase)
            PH_OPEN: begin
                o_run_last = (r_cmd.body == ujse_pkg::BODY_NONE) &&
                             (r_cmd.tail == ujse_pkg::TAIL_NONE);
            end
            PH_BODY: begin
                o_run_last = w_body_last && (r_cmd.tail == ujse_pkg::TAIL_NONE);
                unique case (r_cmd.body)
                    ujse_pkg::BODY_CHAR: o_out_char = r_cmd.ch;
                    ujse_pkg::BODY_BSLC:
                        o_out_char = (r_j == 4'd0) ? ujse_pkg::CH_BSLC : r_cmd.ch;
                    default:             o_out_char = w_body_ch;
                endcase
            end
            default: begin
                o_run_last = 1'b1;
                if (r_cmd.tail == ujse_pkg::TAIL_ERR) begin
                    o_out_char = 7'h00;
                    o_bad_utf8 = 1'b1;
                end else begin
                    o_string_end = 1'b1;
                end
            end
        endcase
    end

    assign o_valid = r_busy;
    assign w_fire  = r_busy && !i_stall;
    assign o_q_pop = i_q_valid && (!r_busy || (w_fire && o_run_last));

    // Sequencing: step through phases, load the next command on the last word.
    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_j     = r_j;
        if (o_q_pop) begin
            n_busy = 1'b1;
            n_j    = 4'd0;
            if (i_q_cmd.open) begin
                n_phase = PH_OPEN;
            end else if (i_q_cmd.body != ujse_pkg::BODY_NONE) begin
                n_phase = PH_BODY;
            end else begin
                n_phase = PH_TAIL;
            end
        end else if (w_fire) begin
            if (o_run_last) begin
                n_busy = 1'b0;
            end else if (r_phase == PH_OPEN) begin
                n_phase = (r_cmd.body != ujse_pkg::BODY_NONE) ? PH_BODY : PH_TAIL;
                n_j     = 4'd0;
            end else if (w_body_last) begin
                n_phase = PH_TAIL;
            end else begin
                n_j = 4'(r_j + 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= PH_OPEN;
            r_j     <= 4'd0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_j     <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    // Taking a command always makes the sequencer busy.
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_busy)
        else $error("command taken but sequencer idle");

    // The tail phase is entered only for commands that have a tail.
    a_tail_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_phase == PH_TAIL) |-> (r_cmd.tail != ujse_pkg::TAIL_NONE))
        else $error("tail phase without a tail");

    // The body phase is entered only for commands that have a body.
    a_body_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_phase == PH_BODY) |-> (r_cmd.body != ujse_pkg::BODY_NONE))
        else $error("body phase without a body");

endmodule

@@ hw/rtl/utf8_json_string_escaper_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_json_string_escaper_core
// Turns a UTF-8 byte stream into a quoted, escaped, ASCII-only JSON string.
//
//   Channel   Direction   Handshake           Payload
//   input     in          i_valid / o_stall   i_in_byte, i_has_byte,
//                                             i_is_first, i_is_last
//   output    out         o_valid / i_stall   o_out_char, o_run_last,
//                                             o_string_end, o_bad_utf8
//
// One input word is accepted per cycle while the command queue has room.
// One input word yields 0 to 13 output words (13 for a surrogate pair
// followed by the closing quote); words without output never enter
// the queue.
// The sustained rate is set by the character sequencer; the queue of
// P_QUEUE_DEPTH commands absorbs bursts of expanding bytes.
// Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
module utf8_json_string_escaper_core #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_has_byte,
    input  logic       i_is_first,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_out_char,
    output logic       o_run_last,
    output logic       o_string_end,
    output logic       o_bad_utf8
);

    logic           w_full;
    logic           w_push;
    logic           w_q_valid;
    logic           w_q_pop;
    ujse_pkg::t_cmd w_push_cmd;
    ujse_pkg::t_cmd w_q_cmd;

    assign o_stall = w_full;

    // Classifier and UTF-8 decoder.
    ujse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in_byte  (i_in_byte),
        .i_has_byte (i_has_byte),
        .i_is_first (i_is_first),
        .i_is_last  (i_is_last),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // Command queue between the two sides.
    ujse_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_q_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // Character sequencer.
    ujse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_cmd      (w_q_cmd),
        .o_q_pop      (w_q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end),
        .o_bad_utf8   (o_bad_utf8)
    );

endmodule

@@ dv/utf8_json_string_escaper_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_json_string_escaper_core_tb
// Self-checking bench for the UTF-8 to JSON string escaper. A directed pass
// covers the byte classes, sequence extremes and error paths. Random strings,
// mostly well formed, then run under several idle and stall mixes. A long
// receiver hold-off fills the block while words keep being offered. Every
// output word is checked against an in-bench model of the escaper.
// ----------------------------------------------------------------------------
module utf8_json_string_escaper_core_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    // Kind of multi-byte sequence in progress; sets the overlong minimum.
    typedef enum logic [1:0] {
        SEQ_NONE  = 2'd0,
        SEQ_TWO   = 2'd1,
        SEQ_THREE = 2'd2,
        SEQ_FOUR  = 2'd3
    } t_seq_kind;

    // One output word as the block should give it.
    typedef struct packed {
        logic [6:0] ch;
        logic       run_last;
        logic       str_end;
        logic       bad;
    } t_out_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_has_byte = 1'b0;
    logic       i_is_first = 1'b0;
    logic       i_is_last = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [6:0] o_out_char;
    logic       o_run_last;
    logic       o_string_end;
    logic       o_bad_utf8;

    utf8_json_string_escaper_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .i_has_byte  (i_has_byte),
        .i_is_first  (i_is_first),
        .i_is_last   (i_is_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_run_last  (o_run_last),
        .o_string_end(o_string_end),
        .o_bad_utf8  (o_bad_utf8)
    );

    always #5 i_clk = ~i_clk;

    // Model state of the escaper.
    logic [1:0]  cont_left = 2'd0;
    logic [20:0] code_acc = 21'd0;
    t_seq_kind   seq_kind = SEQ_NONE;
    logic        aborted = 1'b0;

    t_out_word   word_chars[$];
    t_out_word   expected_chars[$];
    t_out_word   want;
    logic [7:0]  utf8_bytes[$];

    int          error_count = 0;
    int          cycle_count = 0;
    int          busy_words = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    logic        hold_req = 1'b0;
    logic        hold_seen = 1'b0;

    // Mismatch reporting: one line each, and a count.
    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [6:0] hex_char(input logic [3:0] n);
        // Lowercase digits: 'a' - 10 is 0x57.
        return (n < 4'd10) ? 7'h30 + 7'(n) : 7'h57 + 7'(n);
    endfunction

    task automatic emit(input logic [6:0] ch, input logic str_end, input logic bad);
        t_out_word w;
        w.ch = ch;
        w.run_last = 1'b0;
        w.str_end = str_end;
        w.bad = bad;
        word_chars.push_back(w);
    endtask

    task automatic emit_escape(input logic [15:0] v);
        emit(ujse_pkg::CH_BSLC, 1'b0, 1'b0);
        emit(ujse_pkg::CH_U, 1'b0, 1'b0);
        for (int s = 12; s >= 0; s -= 4)
            emit(hex_char(v[s+:4]), 1'b0, 1'b0);
    endtask

    // Invalid UTF-8: one error word, then the string is dropped.
    task automatic abort_string();
        emit(7'h00, 1'b0, 1'b1);
        aborted = 1'b1;
        cont_left = 2'd0;
        code_acc = 21'd0;
        seq_kind = SEQ_NONE;
    endtask

    // Range, overlong and surrogate checks on a completed sequence.
    task automatic close_sequence();
        logic [20:0] cp;
        logic [20:0] minimum;
        cp = code_acc;
        minimum = (seq_kind == SEQ_TWO) ? 21'h80 :
                  (seq_kind == SEQ_THREE) ? 21'h800 : 21'h10000;
        seq_kind = SEQ_NONE;
        code_acc = 21'd0;
        if (cp < minimum || cp > 21'h10ffff || (cp >= 21'hd800 && cp <= 21'hdfff)) begin
            abort_string();
        end else if (cp < 21'h10000) begin
            emit_escape(cp[15:0]);
        end else begin
            cp = cp - 21'h10000;
            emit_escape(16'hd800 + 16'(cp[19:10]));
            emit_escape(16'hdc00 + 16'(cp[9:0]));
        end
    endtask

    task automatic take_byte(input logic [7:0] c);
        if (cont_left != 2'd0) begin
            if (c[7:6] != 2'b10) begin
                abort_string();
            end else begin
                code_acc = {code_acc[14:0], c[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                    close_sequence();
            end
        end else if (c[6:0] == ujse_pkg::CH_QUOTE && !c[7] ||
                     c[6:0] == ujse_pkg::CH_BSLC && !c[7]) begin
            emit(ujse_pkg::CH_BSLC, 1'b0, 1'b0);
            emit(c[6:0], 1'b0, 1'b0);
        end else if (c < 8'h20) begin
            emit_escape({8'h00, c});
        end else if (c < 8'h80) begin
            emit(c[6:0], 1'b0, 1'b0);
        end else if (c >= 8'hc2 && c <= 8'hdf) begin
            cont_left = 2'd1;
            seq_kind = SEQ_TWO;
            code_acc = 21'(c[4:0]);
        end else if (c >= 8'he0 && c <= 8'hef) begin
            cont_left = 2'd2;
            seq_kind = SEQ_THREE;
            code_acc = 21'(c[3:0]);
        end else if (c >= 8'hf0 && c <= 8'hf4) begin
            cont_left = 2'd3;
            seq_kind = SEQ_FOUR;
            code_acc = 21'(c[2:0]);
        end else begin
            abort_string();
        end
    endtask

    // Expected output words of one accepted input word, appended in order.
    task automatic escape_word(input logic [7:0] b, input logic has, input logic first,
                               input logic last);
        t_out_word w;
        word_chars.delete();
        if (first) begin
            cont_left = 2'd0;
            code_acc = 21'd0;
            seq_kind = SEQ_NONE;
            aborted = 1'b0;
            emit(ujse_pkg::CH_QUOTE, 1'b0, 1'b0);
        end
        if (!aborted && has)
            take_byte(b);
        if (!aborted && last) begin
            if (cont_left != 2'd0)
                abort_string();
            else
                emit(ujse_pkg::CH_QUOTE, 1'b1, 1'b0);
        end
        if (word_chars.size() != 0) begin
            w = word_chars.pop_back();
            w.run_last = 1'b1;
            word_chars.push_back(w);
            busy_words++;
        end
        foreach (word_chars[k])
            expected_chars.push_back(word_chars[k]);
    endtask

    // Monitor: model on input acceptance, then compare each output word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                escape_word(i_in_byte, i_has_byte, i_is_first, i_is_last);
            if (o_valid && !i_stall) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected word char=%02h", o_out_char));
                end else begin
                    want = expected_chars.pop_front();
                    if (o_out_char !== want.ch)
                        report_mismatch($sformatf("out_char %02h, want %02h",
                                                  o_out_char, want.ch));
                    if (o_run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, want %b",
                                                  o_run_last, want.run_last));
                    if (o_string_end !== want.str_end)
                        report_mismatch($sformatf("string_end %b, want %b",
                                                  o_string_end, want.str_end));
                    if (o_bad_utf8 !== want.bad)
                        report_mismatch($sformatf("bad_utf8 %b, want %b",
                                                  o_bad_utf8, want.bad));
                end
            end
        end
    end

    // Receiver stall: random, or forced high during a hold-off.
    always @(negedge i_clk)
        i_stall = (hold_left != 0) || ($urandom_range(99) < stall_pct);

    // Hold-off counter; a toggle of hold_req starts a new stretch.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one word after an optional random gap and wait for acceptance.
    task automatic send_word(input logic [7:0] b, input logic has, input logic first,
                             input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_in_byte = b;
        i_has_byte = has;
        i_is_first = first;
        i_is_last = last;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic release_bus();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // UTF-8 encoding of a code point into the byte buffer.
    task automatic encode_cp(input logic [20:0] cp);
        if (cp < 21'h80) begin
            utf8_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            utf8_bytes.push_back({3'b110, cp[10:6]});
            utf8_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            utf8_bytes.push_back({4'b1110, cp[15:12]});
            utf8_bytes.push_back({2'b10, cp[11:6]});
            utf8_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            utf8_bytes.push_back({5'b11110, cp[20:18]});
            utf8_bytes.push_back({2'b10, cp[17:12]});
            utf8_bytes.push_back({2'b10, cp[11:6]});
            utf8_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    // One unit of a random string: a clean character or a broken sequence.
    task automatic add_unit(input bit clean);
        int kind;
        logic [20:0] cp;
        kind = clean ? $urandom_range(5) : $urandom_range(11, 6);
        case (kind)
            0: utf8_bytes.push_back(8'($urandom_range(8'h7e, 8'h20)));
            1: utf8_bytes.push_back(8'($urandom_range(8'h1f)));
            2: begin
                case ($urandom_range(2))
                    0: utf8_bytes.push_back(8'h22);
                    1: utf8_bytes.push_back(8'h5c);
                    default: utf8_bytes.push_back(8'h7f);
                endcase
            end
            3: encode_cp(21'($urandom_range(21'h7ff, 21'h80)));
            4: begin
                cp = 21'($urandom_range(21'hffff, 21'h800));
                // Steer clear of the surrogate block.
                if (cp >= 21'hd800 && cp <= 21'hdfff)
                    cp = cp ^ 21'h4000;
                encode_cp(cp);
            end
            5: encode_cp(21'($urandom_range(21'h10ffff, 21'h10000)));
            6: utf8_bytes.push_back(8'($urandom_range(255)));
            7: begin
                if ($urandom_range(1))
                    utf8_bytes.push_back(8'($urandom_range(8'hc1, 8'h80)));
                else
                    utf8_bytes.push_back(8'($urandom_range(8'hff, 8'hf5)));
            end
            8: begin
                // Overlong three- or four-byte coding.
                if ($urandom_range(1)) begin
                    utf8_bytes.push_back(8'he0);
                    utf8_bytes.push_back(8'($urandom_range(8'h9f, 8'h80)));
                end else begin
                    utf8_bytes.push_back(8'hf0);
                    utf8_bytes.push_back(8'($urandom_range(8'h8f, 8'h80)));
                    utf8_bytes.push_back(cont_byte());
                end
                utf8_bytes.push_back(cont_byte());
            end
            9: begin
                utf8_bytes.push_back(8'hed);
                utf8_bytes.push_back(8'($urandom_range(8'hbf, 8'ha0)));
                utf8_bytes.push_back(cont_byte());
            end
            10: begin
                utf8_bytes.push_back(8'hf4);
                utf8_bytes.push_back(8'($urandom_range(8'hbf, 8'h90)));
                utf8_bytes.push_back(cont_byte());
                utf8_bytes.push_back(cont_byte());
            end
            default: begin
                // Sequence cut one byte short.
                encode_cp(21'($urandom_range(21'h10ffff, 21'h80)));
                void'(utf8_bytes.pop_back());
            end
        endcase
    endtask

    // One random string, framed with the occasional missing or late mark.
    task automatic send_random_string(input int clean_pct);
        int  units;
        bit  with_first;
        bit  with_last;
        bit  late_last;
        utf8_bytes.delete();
        units = $urandom_range(6);
        for (int u = 0; u < units; u++)
            add_unit($urandom_range(99) < clean_pct);
        with_first = ($urandom_range(99) >= 6);
        with_last = ($urandom_range(99) >= 6);
        late_last = ($urandom_range(99) < 12);
        if (utf8_bytes.size() == 0) begin
            send_word(8'($urandom_range(255)), 1'b0, with_first, with_last);
        end else begin
            foreach (utf8_bytes[k])
                send_word(utf8_bytes[k], 1'b1, with_first && k == 0,
                          with_last && !late_last && k == utf8_bytes.size() - 1);
            if (with_last && late_last)
                send_word(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1);
        end
    endtask

    // Directed pass: byte classes, sequence extremes and each error path.
    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        // Empty string.
        send_word(8'h00, 1'b0, 1'b1, 1'b1);
        // Controls, quote, backslash, DEL, smallest and largest two-byte.
        send_word(8'h00, 1'b1, 1'b1, 1'b0);
        send_word(8'h1f, 1'b1, 1'b0, 1'b0);
        send_word(8'h22, 1'b1, 1'b0, 1'b0);
        send_word(8'h5c, 1'b1, 1'b0, 1'b0);
        send_word(8'h7f, 1'b1, 1'b0, 1'b0);
        send_word(8'hc2, 1'b1, 1'b0, 1'b0);
        send_word(8'h80, 1'b1, 1'b0, 1'b0);
        send_word(8'hdf, 1'b1, 1'b0, 1'b0);
        send_word(8'hbf, 1'b1, 1'b0, 1'b1);
        // U+FFFF, U+10FFFF, closed by a word without a byte.
        send_word(8'hef, 1'b1, 1'b1, 1'b0);
        send_word(8'hbf, 1'b1, 1'b0, 1'b0);
        send_word(8'hbf, 1'b1, 1'b0, 1'b0);
        send_word(8'hf4, 1'b1, 1'b0, 1'b0);
        send_word(8'h8f, 1'b1, 1'b0, 1'b0);
        send_word(8'hbf, 1'b1, 1'b0, 1'b0);
        send_word(8'hbf, 1'b1, 1'b0, 1'b0);
        send_word(8'hff, 1'b0, 1'b0, 1'b1);
        // Missing first mark, then a word with neither byte nor marks.
        send_word(8'h41, 1'b1, 1'b0, 1'b0);
        send_word(8'h55, 1'b0, 1'b0, 1'b0);
        // Bad lead byte; the rest of the string is dropped.
        send_word(8'hff, 1'b1, 1'b1, 1'b0);
        send_word(8'h41, 1'b1, 1'b0, 1'b1);
        // Missing continuation.
        send_word(8'hc3, 1'b1, 1'b1, 1'b0);
        send_word(8'h41, 1'b1, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0, 1'b1);
        // Truncated at the end of the string.
        send_word(8'he2, 1'b1, 1'b1, 1'b0);
        send_word(8'h82, 1'b1, 1'b0, 1'b1);
        // Encoded surrogate.
        send_word(8'hed, 1'b1, 1'b1, 1'b0);
        send_word(8'ha0, 1'b1, 1'b0, 1'b0);
        send_word(8'h80, 1'b1, 1'b0, 1'b1);
        release_bus();
    endtask

    // Random strings under one idle/stall mix until enough words did work.
    task automatic test_random(input int send_idle, input int recv_stall, input int n_words);
        int start;
        idle_pct = send_idle;
        stall_pct = recv_stall;
        start = busy_words;
        while (busy_words - start < n_words)
            send_random_string(95);
        release_bus();
    endtask

    // Long receiver hold-off while clean strings keep coming.
    task automatic test_backpressure();
        int start;
        idle_pct = 0;
        stall_pct = 0;
        start = busy_words;
        @(negedge i_clk);
        hold_req = ~hold_req;
        while (busy_words - start < 24)
            send_random_string(100);
        release_bus();
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(0, 0, 36);
        test_random(51, 0, 36);
        test_random(0, 51, 36);
        test_random(25, 25, 36);
        test_backpressure();

        idle_pct = 0;
        stall_pct = 0;
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
